### hw/rtl/tile_opaque_bounding_trim_assert.svh
// Assertion macros shared by the tile trim RTL.
// Expects signals clk and arst_n in the scope where a macro is used.
`ifndef TILE_OPAQUE_BOUNDING_TRIM_ASSERT_SVH
`define TILE_OPAQUE_BOUNDING_TRIM_ASSERT_SVH
`ifndef NO_ASSERTIONS
// prop is a property expression, checked every clock outside reset
`define TOBT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// expr must never be true outside reset
`define TOBT_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define TOBT_ASSERT(lbl, prop, msg)
`define TOBT_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

### hw/rtl/tobt_pkg.sv
// Package for the tile bounding-box trim block: sizes, register indexes,
// the tracker status struct and the side-clamp helper. No dependencies.
`default_nettype none
package tobt_pkg;
	localparam int MAX_SIDE    = 1024;
	localparam int PIXEL_BYTES = 4;
	localparam int SIDE_W      = $clog2(MAX_SIDE);   // column/row index width
	localparam int LEN_W       = SIDE_W + 1;         // holds MAX_SIDE itself
	localparam int PIX_W       = 32;
	localparam int SIZE_REG_W  = 11;
	localparam int COORD_W     = 16;
	localparam int OUT_C_W     = 17;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam logic [PIX_W-1:0] PIX_MASK =
		PIX_W'((64'd1 << (8 * PIXEL_BYTES)) - 64'd1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TILE_WIDTH  = 3'd0,
		REG_TILE_HEIGHT = 3'd1,
		REG_ORIGIN_X    = 3'd2,
		REG_ORIGIN_Y    = 3'd3,
		REG_HOT_X       = 3'd4,
		REG_HOT_Y       = 3'd5
	} cfg_reg_t;

	// Tracker view of the pixel being stepped, after its own update.
	typedef struct packed {
		logic              tile_end;
		logic              found;
		logic [SIDE_W-1:0] min_col;
		logic [SIDE_W-1:0] max_col;
		logic [SIDE_W-1:0] min_row;
		logic [SIDE_W-1:0] max_row;
	} bbox_t;

	// Zero counts as one, anything above MAX_SIDE saturates.
	function automatic logic [LEN_W-1:0] eff_side(input logic [SIZE_REG_W-1:0] v);
		logic [LEN_W-1:0] r;
		if (v == '0) begin
			r = LEN_W'(1);
		end else if (32'(v) > MAX_SIDE) begin
			r = LEN_W'(MAX_SIDE);
		end else begin
			r = LEN_W'(v);
		end
		return r;
	endfunction
endpackage
`default_nettype wire

### hw/rtl/tobt_if.sv
// Valid/ready channel interfaces for pixels in and trim results out.
// Depends on tobt_pkg.
`default_nettype none
interface tobt_pixel_if
	import tobt_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;
	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

interface tobt_result_if
	import tobt_pkg::*;
;
	logic                      valid;
	logic                      ready;
	logic [OUT_C_W-1:0]        new_x;
	logic [OUT_C_W-1:0]        new_y;
	logic [SIZE_REG_W-1:0]     new_width;
	logic [SIZE_REG_W-1:0]     new_height;
	logic signed [OUT_C_W-1:0] new_hot_x;
	logic signed [OUT_C_W-1:0] new_hot_y;
	logic                      all_clear;
	modport source (output valid, output new_x, output new_y, output new_width,
		output new_height, output new_hot_x, output new_hot_y, output all_clear,
		input ready);
	modport sink (input valid, input new_x, input new_y, input new_width,
		input new_height, input new_hot_x, input new_hot_y, input all_clear,
		output ready);
endinterface
`default_nettype wire

### hw/rtl/tile_opaque_bounding_trim.sv
// Top level of the tile bounding-box trim block: config registers, input
// stage, tracker instance and result register. Depends on tobt_pkg,
// tobt_if, tobt_track and the assertion macro header.
//
//  channel | dir | payload                                          | handshake
//  --------+-----+--------------------------------------------------+-------------
//  pixels  | in  | pixel[31:0]                                      | valid/ready
//  result  | out | new_x,new_y,new_width,new_height,new_hot_x/y,    | valid/ready
//          |     | all_clear                                        |
//  cfg     | in  | cfg_index[2:0], cfg_data[15:0]                   | cfg_wen only
//
// One pixel per cycle sustained while the result channel does not stall. The
// tracker updates the bounding box while a pixel sits in the input stage; when
// the last pixel of a tile steps out of the input stage, the trimmed result is
// registered into the output register, and result valid rises with it.
// The input stage advances whenever the output register is empty or its
// result transfers in that cycle, so a stalled result holds one pixel in the
// input stage and then backpressures the pixel channel.
// Reset (arst_n low, asynchronous) restores register defaults: 16x16 tile,
// zero origin and hotspot, empty pipeline and fresh tracking.
`default_nettype none
`include "tile_opaque_bounding_trim_assert.svh"
module tile_opaque_bounding_trim
	import tobt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	tobt_pixel_if.sink                 pixels,
	tobt_result_if.source              result,
	input  wire logic                  cfg_wen,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);
	// configuration registers
	logic [SIZE_REG_W-1:0] tile_width_q, tile_height_q;
	logic [COORD_W-1:0]    origin_x_q, origin_y_q, hot_x_q, hot_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_width_q  <= SIZE_REG_W'(16);
			tile_height_q <= SIZE_REG_W'(16);
			origin_x_q    <= '0;
			origin_y_q    <= '0;
			hot_x_q       <= '0;
			hot_y_q       <= '0;
		end else if (cfg_wen) begin
			case (cfg_reg_t'(cfg_index))
				REG_TILE_WIDTH: begin
					tile_width_q <= cfg_data[SIZE_REG_W-1:0];
				end
				REG_TILE_HEIGHT: begin
					tile_height_q <= cfg_data[SIZE_REG_W-1:0];
				end
				REG_ORIGIN_X: begin
					origin_x_q <= cfg_data[COORD_W-1:0];
				end
				REG_ORIGIN_Y: begin
					origin_y_q <= cfg_data[COORD_W-1:0];
				end
				REG_HOT_X: begin
					hot_x_q <= cfg_data[COORD_W-1:0];
				end
				REG_HOT_Y: begin
					hot_y_q <= cfg_data[COORD_W-1:0];
				end
				default: begin
					// unused index: write dropped
				end
			endcase
		end
	end

	// input stage
	logic             valid_s1;
	logic [PIX_W-1:0] pixel_s1;
	logic             out_valid_q;
	logic             advance;
	logic             step;

	// output register free this cycle: empty, or its result transfers now
	assign advance      = !out_valid_q || result.ready;
	assign pixels.ready = !valid_s1 || advance;
	assign step         = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixels.ready) begin
			valid_s1 <= pixels.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pixels.ready && pixels.valid) begin
			pixel_s1 <= pixels.pixel;
		end
	end

	// bounding-box tracker
	bbox_t bbox;

	tobt_track u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.pixel_nz   (step && ((pixel_s1 & PIX_MASK) != '0)),
		.width_eff  (eff_side(tile_width_q)),
		.height_eff (eff_side(tile_height_q)),
		.bbox       (bbox)
	);

	// trim arithmetic; a clear tile trims nothing and reports zero size
	logic [SIDE_W-1:0]         trim_x, trim_y;
	logic [LEN_W-1:0]          span_x, span_y;
	logic [OUT_C_W-1:0]        new_x_d, new_y_d;
	logic signed [OUT_C_W-1:0] new_hot_x_d, new_hot_y_d;
	logic [SIZE_REG_W-1:0]     new_width_d, new_height_d;

	always_comb begin
		trim_x       = bbox.found ? bbox.min_col : '0;
		trim_y       = bbox.found ? bbox.min_row : '0;
		span_x       = LEN_W'(bbox.max_col) - LEN_W'(bbox.min_col) + LEN_W'(1);
		span_y       = LEN_W'(bbox.max_row) - LEN_W'(bbox.min_row) + LEN_W'(1);
		new_x_d      = OUT_C_W'(origin_x_q) + OUT_C_W'(trim_x);
		new_y_d      = OUT_C_W'(origin_y_q) + OUT_C_W'(trim_y);
		new_hot_x_d  = {hot_x_q[COORD_W-1], hot_x_q} + OUT_C_W'(trim_x);
		new_hot_y_d  = {hot_y_q[COORD_W-1], hot_y_q} + OUT_C_W'(trim_y);
		new_width_d  = bbox.found ? SIZE_REG_W'(span_x) : '0;
		new_height_d = bbox.found ? SIZE_REG_W'(span_y) : '0;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && bbox.tile_end;
		end
	end

	logic [OUT_C_W-1:0]        new_x_q, new_y_q;
	logic signed [OUT_C_W-1:0] new_hot_x_q, new_hot_y_q;
	logic [SIZE_REG_W-1:0]     new_width_q, new_height_q;
	logic                      all_clear_q;

	always_ff @(posedge clk) begin
		if (step && bbox.tile_end) begin
			new_x_q      <= new_x_d;
			new_y_q      <= new_y_d;
			new_width_q  <= new_width_d;
			new_height_q <= new_height_d;
			new_hot_x_q  <= new_hot_x_d;
			new_hot_y_q  <= new_hot_y_d;
			all_clear_q  <= !bbox.found;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.new_x      = new_x_q;
	assign result.new_y      = new_y_q;
	assign result.new_width  = new_width_q;
	assign result.new_height = new_height_q;
	assign result.new_hot_x  = new_hot_x_q;
	assign result.new_hot_y  = new_hot_y_q;
	assign result.all_clear  = all_clear_q;

	`TOBT_ASSERT_NEVER(a_clear_size, out_valid_q && all_clear_q && (new_width_q != '0 || new_height_q != '0), "clear tile with nonzero size")
	`TOBT_ASSERT_NEVER(a_found_size, out_valid_q && !all_clear_q && (new_width_q == '0 || new_height_q == '0), "opaque tile with zero size")
	`TOBT_ASSERT(a_s1_hold, (valid_s1 && !advance) |=> valid_s1, "input stage dropped a stalled pixel")
endmodule
`default_nettype wire

### hw/rtl/tobt_track.sv
// Raster position counters and nonzero bounding-box tracking.
// Depends on tobt_pkg and the assertion macro header.
`default_nettype none
`include "tile_opaque_bounding_trim_assert.svh"
module tobt_track
	import tobt_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic             pixel_nz,
	input  wire logic [LEN_W-1:0] width_eff,
	input  wire logic [LEN_W-1:0] height_eff,
	output bbox_t                 bbox
);
	logic [SIDE_W-1:0] col_q, row_q;
	logic [SIDE_W-1:0] min_col_q, max_col_q, min_row_q, max_row_q;
	logic              found_q;

	logic              col_last, row_last;
	logic [SIDE_W-1:0] min_col_n, max_col_n, min_row_n, max_row_n;

	assign col_last = (LEN_W'(col_q) + LEN_W'(1)) >= width_eff;
	assign row_last = (LEN_W'(row_q) + LEN_W'(1)) >= height_eff;

	always_comb begin
		min_col_n = min_col_q;
		max_col_n = max_col_q;
		min_row_n = min_row_q;
		max_row_n = max_row_q;
		if (pixel_nz) begin
			if (!found_q) begin
				min_col_n = col_q;
				max_col_n = col_q;
				min_row_n = row_q;
				max_row_n = row_q;
			end else begin
				if (col_q < min_col_q) min_col_n = col_q;
				if (col_q > max_col_q) max_col_n = col_q;
				if (row_q < min_row_q) min_row_n = row_q;
				if (row_q > max_row_q) max_row_n = row_q;
			end
		end
	end

	assign bbox.tile_end = col_last & row_last;
	assign bbox.found    = found_q | pixel_nz;
	assign bbox.min_col  = min_col_n;
	assign bbox.max_col  = max_col_n;
	assign bbox.min_row  = min_row_n;
	assign bbox.max_row  = max_row_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			min_col_q <= '1;
			max_col_q <= '0;
			min_row_q <= '1;
			max_row_q <= '0;
			found_q   <= 1'b0;
		end else if (step) begin
			if (bbox.tile_end) begin
				col_q     <= '0;
				row_q     <= '0;
				min_col_q <= '1;
				max_col_q <= '0;
				min_row_q <= '1;
				max_row_q <= '0;
				found_q   <= 1'b0;
			end else begin
				col_q     <= col_last ? '0 : col_q + SIDE_W'(1);
				row_q     <= col_last ? row_q + SIDE_W'(1) : row_q;
				min_col_q <= min_col_n;
				max_col_q <= max_col_n;
				min_row_q <= min_row_n;
				max_row_q <= max_row_n;
				found_q   <= bbox.found;
			end
		end
	end

	`TOBT_ASSERT_NEVER(a_col_order, found_q && (min_col_q > max_col_q), "min column above max")
	`TOBT_ASSERT_NEVER(a_row_order, found_q && (min_row_q > max_row_q), "min row above max")
	`TOBT_ASSERT(a_tile_restart, (step && bbox.tile_end) |=> (col_q == '0 && row_q == '0 && !found_q), "tracking not cleared after tile end")
endmodule
`default_nettype wire

### dv/tile_opaque_bounding_trim_tb.sv
// Self-checking bench for tile_opaque_bounding_trim: pixel tiles go in under random
// stalls on both channels and every trim result is checked against an in-bench tracker.
// Depends on tobt_pkg, tobt_if and the RTL top level.
`default_nettype none
module tile_opaque_bounding_trim_tb;
	import tobt_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYC    = 9;
	localparam int DRAIN_CYC    = 6;       // pipeline is two deep, leave some slack
	localparam int CYCLE_CAP    = 200000;
	localparam int MAX_REPORTS  = 10;
	localparam int SMALL_ITEMS  = 800;     // small-tile pixels after the directed tiles
	localparam int IDLE_PCT     = 37;
	localparam int NO_IDLE_PHASE = 3;
	localparam int NO_IDLE_ITEMS = 400;    // pixels in the phase with no idling
	// indexes past the register list; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	// one trimmed tile as it leaves the block
	typedef struct packed {
		logic [OUT_C_W-1:0]    new_x;
		logic [OUT_C_W-1:0]    new_y;
		logic [SIZE_REG_W-1:0] new_width;
		logic [SIZE_REG_W-1:0] new_height;
		logic [OUT_C_W-1:0]    new_hot_x;
		logic [OUT_C_W-1:0]    new_hot_y;
		logic                  all_clear;
	} trim_rec_t;

	// all block inputs start known at time zero
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  pix_valid = 1'b0;
	logic [PIX_W-1:0]      pix_data = '0;
	logic                  res_ready = 1'b0;
	logic                  cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	tobt_pixel_if  pix_ch ();
	tobt_result_if res_ch ();

	assign pix_ch.valid = pix_valid;
	assign pix_ch.pixel = pix_data;
	assign res_ch.ready = res_ready;

	tile_opaque_bounding_trim dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixels   (pix_ch),
		.result   (res_ch),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// pixels waiting for the driver, trims waiting for the monitor
	logic [PIX_W-1:0] pixel_q[$];
	trim_rec_t        trim_expected_q[$];

	int in_idle_pct = IDLE_PCT;
	int out_idle_pct = IDLE_PCT;
	int mismatches = 0;
	int results_seen = 0;
	int cycles = 0;
	int random_pixels = 0;

	// shadow of the register file, updated once the write has landed
	logic [SIZE_REG_W-1:0] reg_width = SIZE_REG_W'(16);
	logic [SIZE_REG_W-1:0] reg_height = SIZE_REG_W'(16);
	logic [COORD_W-1:0]    reg_org_x = '0;
	logic [COORD_W-1:0]    reg_org_y = '0;
	logic [COORD_W-1:0]    reg_hot_x = '0;
	logic [COORD_W-1:0]    reg_hot_y = '0;

	// bounding-box tracker of the tile in flight
	int col_at, row_at, lo_col, hi_col, lo_row, hi_row;
	bit any_opaque;

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// zero acts as one, anything past MAX_SIDE saturates
	function automatic int side_len(input logic [SIZE_REG_W-1:0] v);
		if (v == '0) return 1;
		return (int'(v) > MAX_SIDE) ? MAX_SIDE : int'(v);
	endfunction

	function automatic void restart_tile();
		col_at = 0;
		row_at = 0;
		lo_col = MAX_SIDE - 1;
		hi_col = 0;
		lo_row = MAX_SIDE - 1;
		hi_row = 0;
		any_opaque = 1'b0;
	endfunction

	// Advance the tracker by one pixel transfer; the last pixel of a tile queues
	// its trim. Sizes are read live, so a shrink mid-tile closes the row at once.
	task automatic trim_step(input logic [PIX_W-1:0] pix);
		int w_len, h_len, col_off, row_off;
		trim_rec_t rec;
		w_len = side_len(reg_width);
		h_len = side_len(reg_height);
		if ((pix & PIX_MASK) != '0) begin
			if (!any_opaque) begin
				lo_col = col_at;
				hi_col = col_at;
				lo_row = row_at;
				hi_row = row_at;
				any_opaque = 1'b1;
			end else begin
				if (col_at < lo_col) lo_col = col_at;
				if (col_at > hi_col) hi_col = col_at;
				if (row_at < lo_row) lo_row = row_at;
				if (row_at > hi_row) hi_row = row_at;
			end
		end
		if (col_at + 1 < w_len) begin
			col_at++;
		end else if (row_at + 1 < h_len) begin
			col_at = 0;
			row_at++;
		end else begin
			// a clear tile keeps origin and hotspot, sizes drop to zero
			col_off = any_opaque ? lo_col : 0;
			row_off = any_opaque ? lo_row : 0;
			rec.new_x      = OUT_C_W'(int'(reg_org_x) + col_off);
			rec.new_y      = OUT_C_W'(int'(reg_org_y) + row_off);
			rec.new_width  = any_opaque ? SIZE_REG_W'(hi_col - lo_col + 1) : '0;
			rec.new_height = any_opaque ? SIZE_REG_W'(hi_row - lo_row + 1) : '0;
			rec.new_hot_x  = OUT_C_W'(int'($signed(reg_hot_x)) + col_off);
			rec.new_hot_y  = OUT_C_W'(int'($signed(reg_hot_y)) + row_off);
			rec.all_clear  = !any_opaque;
			trim_expected_q.push_back(rec);
			restart_tile();
		end
	endtask

	task automatic field_check(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			if (mismatches < MAX_REPORTS)
				$display("result %0d: %s expected 0x%0h, got 0x%0h",
					results_seen, name, want, got);
			mismatches++;
		end
	endtask

	// Driver: a pixel transfer happens at an edge with valid and ready high.
	// The tracker steps on the transfer, then the next pixel (or a gap) is set up.
	always @(posedge clk) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
		end else begin
			if (pix_valid && pix_ch.ready) begin
				trim_step(pix_data);
			end
			if (!pix_valid || pix_ch.ready) begin
				if (pixel_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
					pix_valid <= 1'b1;
					pix_data <= pixel_q.pop_front();
				end else begin
					pix_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: each result transfer is matched against the oldest pending trim.
	always @(posedge clk) begin : result_mon
		trim_rec_t want;
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_ready && res_ch.valid) begin
				if (trim_expected_q.size() == 0) begin
					if (mismatches < MAX_REPORTS)
						$display("result transfer with no trim pending");
					mismatches++;
				end else begin
					want = trim_expected_q.pop_front();
					field_check("new_x", 32'(want.new_x), 32'(res_ch.new_x));
					field_check("new_y", 32'(want.new_y), 32'(res_ch.new_y));
					field_check("new_width", 32'(want.new_width), 32'(res_ch.new_width));
					field_check("new_height", 32'(want.new_height),
						32'(res_ch.new_height));
					// compare the raw 17 bits of the signed hotspot fields
					field_check("new_hot_x", 32'(want.new_hot_x),
						32'($unsigned(res_ch.new_hot_x)));
					field_check("new_hot_y", 32'(want.new_hot_y),
						32'($unsigned(res_ch.new_hot_y)));
					field_check("all_clear", 32'(want.all_clear), 32'(res_ch.all_clear));
				end
				results_seen++;
			end
			res_ready <= ($urandom_range(99) >= out_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("tile_opaque_bounding_trim regression: fail");
			$finish;
		end
	end

	// One register write; the shadow follows once the block has taken it.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			REG_TILE_WIDTH:  reg_width = val[SIZE_REG_W-1:0];
			REG_TILE_HEIGHT: reg_height = val[SIZE_REG_W-1:0];
			REG_ORIGIN_X:    reg_org_x = val;
			REG_ORIGIN_Y:    reg_org_y = val;
			REG_HOT_X:       reg_hot_x = val;
			REG_HOT_Y:       reg_hot_y = val;
			default: ;
		endcase
	endtask

	// Everything sent has transferred and every trim has come back. A partial
	// tile leaves nothing pending, so a drain wait follows to let the block settle.
	task automatic wait_idle();
		while (pixel_q.size() != 0 || pix_valid || trim_expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	function automatic logic [PIX_W-1:0] opaque_pixel();
		logic [PIX_W-1:0] v;
		if ($urandom_range(3) == 0) v = PIX_W'(1) << $urandom_range(PIX_W - 1);
		else v = PIX_W'($urandom());
		if (v == '0) v = ~v;
		return v;
	endfunction

	task automatic queue_pixels(input int n, input int fill_pct);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < fill_pct) pixel_q.push_back(opaque_pixel());
			else pixel_q.push_back('0);
		end
		random_pixels += n;
	endtask

	// long strip: clear up to a point near the far end, so the trim offset
	// lands close to the largest index
	task automatic queue_strip(input int n);
		int first;
		first = n - 1 - $urandom_range(3);
		for (int i = 0; i < n; i++) begin
			if (i == first || (i > first && $urandom_range(1) == 1))
				pixel_q.push_back(opaque_pixel());
			else
				pixel_q.push_back('0);
		end
		random_pixels += n;
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_coord();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return 16'h8000;
			3: return 16'h7FFF;
			default: return CFG_DATA_W'($urandom());
		endcase
	endfunction

	// small side, junk above the register width now and then
	function automatic logic [CFG_DATA_W-1:0] pick_side();
		logic [CFG_DATA_W-1:0] v;
		v = CFG_DATA_W'($urandom_range(9));
		if ($urandom_range(3) == 0) v[CFG_DATA_W-1:SIZE_REG_W] = 5'($urandom());
		return v;
	endfunction

	function automatic int pick_fill();
		case ($urandom_range(5))
			0: return 0;
			1: return 100;
			default: return $urandom_range(5, 60);
		endcase
	endfunction

	initial begin : stimulus
		int phase_no, tiles, area;
		restart_tile();
		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default 16-wide rows, height register zero acts as one row
		write_reg(REG_TILE_HEIGHT, '0);
		for (int i = 0; i < 16; i++) begin
			if (i == 3) pixel_q.push_back(32'h0000_0001);
			else if (i == 12) pixel_q.push_back(32'h8000_0000);
			else pixel_q.push_back('0);
		end
		wait_idle();

		// 1x1 tiles at the coordinate extremes: one clear, one fully set
		write_reg(REG_TILE_WIDTH, '0);
		write_reg(REG_ORIGIN_X, '1);
		write_reg(REG_ORIGIN_Y, '1);
		write_reg(REG_HOT_X, 16'h7FFF);
		write_reg(REG_HOT_Y, 16'h8000);
		pixel_q.push_back('0);
		pixel_q.push_back('1);
		wait_idle();

		// width all ones saturates to the max side; three pixels in, shrink to
		// two columns, and the next pixel must close the row and the tile
		write_reg(REG_TILE_WIDTH, '1);
		pixel_q.push_back('0);
		pixel_q.push_back(32'h00FF_0000);
		pixel_q.push_back('0);
		wait_idle();
		write_reg(REG_TILE_WIDTH, CFG_DATA_W'(2));
		pixel_q.push_back(32'h5A5A_5A5A);
		wait_idle();

		// writes past the register list must change nothing
		write_reg(REG_TILE_HEIGHT, CFG_DATA_W'(2));
		write_reg(REG_SPARE_A, '1);
		write_reg(REG_SPARE_B, '0);
		pixel_q.push_back('0);
		pixel_q.push_back('0);
		pixel_q.push_back('0);
		pixel_q.push_back(32'h0000_0100);
		wait_idle();

		// full-width row with the trim near its far end, origin and hotspot at max
		write_reg(REG_TILE_WIDTH, CFG_DATA_W'(MAX_SIDE));
		write_reg(REG_TILE_HEIGHT, CFG_DATA_W'(1));
		write_reg(REG_ORIGIN_X, '1);
		write_reg(REG_HOT_X, 16'h7FFF);
		queue_strip(MAX_SIDE);
		wait_idle();

		// one-wide column, height register just past the max side saturates, so
		// six rows in the tile is still open; a shrink to two rows closes it on
		// the next pixel
		write_reg(REG_TILE_WIDTH, CFG_DATA_W'(1));
		write_reg(REG_TILE_HEIGHT, CFG_DATA_W'(MAX_SIDE + 1));
		write_reg(REG_ORIGIN_Y, '1);
		write_reg(REG_HOT_Y, 16'h7FFF);
		for (int i = 0; i < 6; i++) begin
			if (i >= 4) pixel_q.push_back(opaque_pixel());
			else pixel_q.push_back('0);
		end
		wait_idle();
		write_reg(REG_TILE_HEIGHT, CFG_DATA_W'(2));
		pixel_q.push_back('0);
		wait_idle();

		// Random phases of small tiles. A phase may end on a partial tile, so the
		// next register change lands mid-tile. One longer phase runs with no idling.
		random_pixels = 0;
		phase_no = 0;
		while (random_pixels < SMALL_ITEMS || phase_no <= NO_IDLE_PHASE) begin
			wait_idle();
			in_idle_pct = (phase_no == NO_IDLE_PHASE) ? 0 : IDLE_PCT;
			out_idle_pct = in_idle_pct;
			write_reg(REG_TILE_WIDTH, pick_side());
			write_reg(REG_TILE_HEIGHT, pick_side());
			if ($urandom_range(2) == 0) write_reg(REG_ORIGIN_X, pick_coord());
			if ($urandom_range(2) == 0) write_reg(REG_ORIGIN_Y, pick_coord());
			if ($urandom_range(2) == 0) write_reg(REG_HOT_X, pick_coord());
			if ($urandom_range(2) == 0) write_reg(REG_HOT_Y, pick_coord());
			area = side_len(reg_width) * side_len(reg_height);
			tiles = (phase_no == NO_IDLE_PHASE) ? (NO_IDLE_ITEMS + area - 1) / area
				: $urandom_range(2, 8);
			for (int t = 0; t < tiles; t++) queue_pixels(area, pick_fill());
			if ($urandom_range(3) == 0) queue_pixels($urandom_range(1, area), 30);
			phase_no++;
		end

		wait_idle();
		if (mismatches == 0 && trim_expected_q.size() == 0) begin
			$display("tile_opaque_bounding_trim regression: pass");
		end else begin
			$display("tile_opaque_bounding_trim regression: fail");
		end
		$finish;
	end
endmodule
`default_nettype wire
